// File: hw/rtl/bmp_pixel_stream_blit_core_macros.svh
// Assertion macros shared by the pixel stream blit RTL.
`ifndef BMP_PIXEL_STREAM_BLIT_CORE_MACROS_SVH
`define BMP_PIXEL_STREAM_BLIT_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define BMPBLIT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BMPBLIT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bmpblit_pkg.sv
// Types and constants shared by the pixel stream blit modules.
`default_nettype none
package bmpblit_pkg;

    localparam int DIM_W      = 14;
    localparam int CNT_W      = 12;
    localparam int ADDR_W     = 19;
    localparam int COLOR_W    = 32;
    localparam int GATHER_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IS_32  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd4;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 14'd800;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 14'd480;

    typedef struct packed {
        logic signed [DIM_W-1:0] image_width;
        logic signed [DIM_W-1:0] image_height;
        logic                    depth_is_32;
        logic signed [DIM_W-1:0] origin_x;
        logic signed [DIM_W-1:0] origin_y;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               in_view;
        logic               last_pixel;
    } t_pixel;

endpackage
`default_nettype wire

// File: hw/rtl/bmp_pixel_stream_blit_core.sv
// Top level of the BMP pixel stream blit: handshake registers around the walk.
// The block takes one pixel-array byte per beat and can accept a byte in every cycle
// while o_stall is low. A byte passes an input register, then the walk logic computes
// the pixel and stores it in the output register, from which the sink takes it. Bytes
// that only gather color or skip row padding give no result. The output register and
// the input register form a two-entry pipeline, so one byte is still taken while a
// finished result waits for the sink. Configuration is written through a plain write
// port; the user must write it only while the block is idle, which the block itself
// does not enforce. No clearing pass follows reset.
`default_nettype none
`include "bmp_pixel_stream_blit_core_macros.svh"
module bmp_pixel_stream_blit_core #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bmpblit_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bmpblit_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [7:0]                          i_pixel_byte,
    input  wire logic                                i_frame_start,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [bmpblit_pkg::ADDR_W-1:0]           o_pixel_address,
    output logic [bmpblit_pkg::COLOR_W-1:0]          o_pixel_color,
    output logic                                     o_in_view,
    output logic                                     o_last_pixel
);

    localparam logic [24:0] AREA = 25'(SCREEN_WIDTH * SCREEN_HEIGHT);

    bmpblit_pkg::t_cfg   cfg;
    bmpblit_pkg::t_pixel res, r_out;
    logic                res_valid;

    logic       r_in_valid, r_out_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fs;
    logic       out_free, proc, in_free;

    bmpblit_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bmpblit_walk #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (proc),
        .i_pixel_byte  (r_in_byte),
        .i_frame_start (r_in_fs),
        .i_cfg         (cfg),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // A byte that gives no result may move on even while the output is held.
    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && (out_free || !res_valid);
    assign in_free  = !r_in_valid || proc;
    assign o_stall  = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_byte <= i_pixel_byte;
            r_in_fs   <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && proc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_address = r_out.pixel_address;
    assign o_pixel_color   = r_out.pixel_color;
    assign o_in_view       = r_out.in_view;
    assign o_last_pixel    = r_out.last_pixel;

    `BMPBLIT_ASSERT(a_stall_needs_byte, i_clk, i_rst_n, o_stall |-> r_in_valid, "input stalled with an empty input register")
    `BMPBLIT_ASSERT(a_clip_address, i_clk, i_rst_n, o_valid && !o_in_view |-> o_pixel_address == '0, "clipped pixel carries an address")
    `BMPBLIT_ASSERT(a_view_in_range, i_clk, i_rst_n, o_valid && o_in_view |-> 25'(o_pixel_address) < AREA, "visible pixel address beyond the framebuffer")
    `BMPBLIT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !o_stall, "handshake active after reset")

endmodule
`default_nettype wire

// File: hw/rtl/bmpblit_cfg.sv
// Configuration register file of the pixel stream blit.
`default_nettype none
module bmpblit_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bmpblit_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bmpblit_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bmpblit_pkg::t_cfg                        o_cfg
);

    bmpblit_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= bmpblit_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height <= bmpblit_pkg::RST_IMAGE_HEIGHT;
            r_cfg.depth_is_32  <= 1'b0;
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmpblit_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                bmpblit_pkg::CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                bmpblit_pkg::CFG_DEPTH_IS_32:  r_cfg.depth_is_32  <= i_cfg_data[0];
                bmpblit_pkg::CFG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_data;
                bmpblit_pkg::CFG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: hw/rtl/bmpblit_walk.sv
// Byte assembly, row and column walk, screen mapping and clipping of one byte.
`default_nettype none
`include "bmp_pixel_stream_blit_core_macros.svh"
module bmpblit_walk #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_pixel_byte,
    input  wire logic              i_frame_start,
    input  wire bmpblit_pkg::t_cfg i_cfg,
    output logic                   o_res_valid,
    output bmpblit_pkg::t_pixel    o_res
);

    localparam int CW = bmpblit_pkg::CNT_W;
    localparam int DW = bmpblit_pkg::DIM_W;
    localparam logic [DW-2:0] MAX_DIM = (DW-1)'(MAX_IMAGE_DIM);
    localparam logic signed [15:0] SW16 = 16'(SCREEN_WIDTH);
    localparam logic signed [15:0] SH16 = 16'(SCREEN_HEIGHT);
    localparam logic [24:0] SW25 = 25'(SCREEN_WIDTH);

    logic [bmpblit_pkg::GATHER_W-1:0] r_gather, n_gather, e_gather;
    logic [1:0]    r_phase, n_phase, e_phase;
    logic [CW-1:0] r_col, n_col, e_col;
    logic [CW-1:0] r_row, n_row, e_row;
    logic [1:0]    r_pad, n_pad, e_pad;
    logic          r_done, n_done, e_done;

    logic [DW-1:0]   absw_raw, absh_raw;
    logic [DW-2:0]   absw, absh;
    logic            dim_zero, w_pos, h_pos, phase_open, col_end, row_end;
    logic signed [15:0] ox16, oy16, col16, row16, absw16, absh16, sx, sy;
    logic            view;
    logic [24:0]     addr_full;
    logic [31:0]     color;

    always_comb begin
        // A frame start clears the walk before its own byte is taken.
        e_gather = i_frame_start ? '0 : r_gather;
        e_phase  = i_frame_start ? '0 : r_phase;
        e_col    = i_frame_start ? '0 : r_col;
        e_row    = i_frame_start ? '0 : r_row;
        e_pad    = i_frame_start ? '0 : r_pad;
        e_done   = i_frame_start ? 1'b0 : r_done;

        absw_raw = i_cfg.image_width[DW-1] ? (~i_cfg.image_width + 1'b1) : i_cfg.image_width;
        absh_raw = i_cfg.image_height[DW-1] ? (~i_cfg.image_height + 1'b1)
                                            : i_cfg.image_height;
        absw = (absw_raw > {1'b0, MAX_DIM}) ? MAX_DIM : absw_raw[DW-2:0];
        absh = (absh_raw > {1'b0, MAX_DIM}) ? MAX_DIM : absh_raw[DW-2:0];
        dim_zero = (absw == '0) || (absh == '0);
        w_pos = !i_cfg.image_width[DW-1];
        h_pos = !i_cfg.image_height[DW-1];

        phase_open = i_cfg.depth_is_32 ? (e_phase < 2'd3) : (e_phase < 2'd2);
        col_end = {1'b0, e_col} >= (absw - 1'b1);
        row_end = {1'b0, e_row} >= (absh - 1'b1);

        color = i_cfg.depth_is_32 ? {i_pixel_byte, e_gather}
                                  : {8'h00, i_pixel_byte, e_gather[15:0]};

        ox16   = {{2{i_cfg.origin_x[DW-1]}}, i_cfg.origin_x};
        oy16   = {{2{i_cfg.origin_y[DW-1]}}, i_cfg.origin_y};
        col16  = $signed({4'b0, e_col});
        row16  = $signed({4'b0, e_row});
        absw16 = $signed({3'b0, absw});
        absh16 = $signed({3'b0, absh});
        sx = w_pos ? (ox16 + col16) : (absw16 + ox16 - 16'sd1 - col16);
        sy = h_pos ? (oy16 + absh16 - 16'sd1 - row16) : (oy16 + row16);
        view = (sx >= 16'sd0) && (sx < SW16) && (sy >= 16'sd0) && (sy < SH16);
        addr_full = 25'(sy[11:0]) * SW25 + 25'(sx[11:0]);

        n_gather = e_gather;
        n_phase  = e_phase;
        n_col    = e_col;
        n_row    = e_row;
        n_pad    = e_pad;
        n_done   = e_done;
        o_res_valid = 1'b0;

        if (e_done || dim_zero) begin
            // Nothing to do beyond the frame start clear.
        end else if (e_pad != 2'd0) begin
            n_pad = e_pad - 2'd1;
        end else if (phase_open) begin
            case (e_phase)
                2'd0:    n_gather[7:0]   = i_pixel_byte;
                2'd1:    n_gather[15:8]  = i_pixel_byte;
                2'd2:    n_gather[23:16] = i_pixel_byte;
                default: begin
                end
            endcase
            n_phase = e_phase + 2'd1;
        end else begin
            o_res_valid = 1'b1;
            n_gather = '0;
            n_phase  = '0;
            if (col_end) begin
                n_col = '0;
                // Three-byte pixels leave width mod 4 padding bytes per row.
                n_pad = i_cfg.depth_is_32 ? 2'd0 : absw[1:0];
                if (row_end) begin
                    n_done = 1'b1;
                end else begin
                    n_row = e_row + 1'b1;
                end
            end else begin
                n_col = e_col + 1'b1;
            end
        end

        o_res.pixel_address = view ? addr_full[bmpblit_pkg::ADDR_W-1:0] : '0;
        o_res.pixel_color   = color;
        o_res.in_view       = view;
        o_res.last_pixel    = col_end && row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_phase  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
            r_done   <= 1'b0;
        end else if (i_step) begin
            r_gather <= n_gather;
            r_phase  <= n_phase;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
            r_done   <= n_done;
        end
    end

    `BMPBLIT_ASSERT(a_last_ends_image, i_clk, i_rst_n, i_step && o_res_valid && o_res.last_pixel |=> r_done, "last pixel did not close the image")

endmodule
`default_nettype wire
